// File: sv/pal_pkg.sv
// pal_pkg: shared types and constants for the positional array list.
// Holds the payload structs, the operation codes, the controller states and
// the command/status structs between pal_ctrl and pal_dp. No dependencies.
package pal_pkg;

    localparam int P_DEPTH      = 256;
    localparam int P_ITEM_WIDTH = 64;
    localparam int POS_W        = 9;
    localparam int VAL_W        = 64;
    localparam int CNT_W        = 9;

    typedef enum logic [0:0] {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [POS_W-1:0] position;
        logic [VAL_W-1:0] item_value;
    } t_item;

    typedef struct packed {
        logic             accepted;
        logic [VAL_W-1:0] removed_value;
        logic [CNT_W-1:0] entry_count;
    } t_result;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_TAKE,
        ST_GRAB,
        ST_SHIFT,
        ST_DRAIN,
        ST_PUT,
        ST_FINISH
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;     // capture the request
        logic init_cur; // set the shift cursor
        logic rd_take;  // read the entry at the position
        logic grab;     // keep the read data as the removed entry
        logic shift;    // read one entry and move the cursor
        logic put;      // write the new entry at the position
        logic finish;   // update count, register the result
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic ok;        // request is legal against the current count
        logic is_remove;
        logic cur_end;   // cursor has reached its stop point
    } t_dp_stat;

endpackage

// File: sv/pal_ctrl.sv
// pal_ctrl: sequencer for the positional array list.
// Steps through evaluate, take, grab, shift, drain, write and finish; uses pal_pkg.
module pal_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  pal_pkg::t_dp_stat  i_stat,
    output pal_pkg::t_dp_cmd   o_cmd,
    output logic               o_busy
);
    import pal_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (!i_stat.ok) begin
                    n_state = ST_FINISH;
                end else if (i_stat.is_remove) begin
                    n_state = ST_TAKE;
                end else begin
                    o_cmd.init_cur = 1'b1;
                    n_state        = ST_SHIFT;
                end
            end
            ST_TAKE: begin
                o_cmd.rd_take = 1'b1;
                n_state       = ST_GRAB;
            end
            ST_GRAB: begin
                o_cmd.grab     = 1'b1;
                o_cmd.init_cur = 1'b1;
                n_state        = ST_SHIFT;
            end
            ST_SHIFT: begin
                if (i_stat.cur_end) begin
                    n_state = ST_DRAIN;
                end else begin
                    o_cmd.shift = 1'b1;
                end
            end
            ST_DRAIN: begin
                // the last shifted entry was written while still in ST_SHIFT; this state is spare
                n_state = i_stat.is_remove ? ST_FINISH : ST_PUT;
            end
            ST_PUT: begin
                o_cmd.put = 1'b1;
                n_state   = ST_FINISH;
            end
            ST_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state      = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule

// File: sv/pal_dp.sv
// pal_dp: datapath of the positional array list.
// Entry memory with one write and one registered read port, count, shift
// cursor and result register; uses pal_pkg.
module pal_dp #(
    parameter int DEPTH      = pal_pkg::P_DEPTH,
    parameter int ITEM_WIDTH = pal_pkg::P_ITEM_WIDTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pal_pkg::t_item    i_item,
    input  pal_pkg::t_dp_cmd  i_cmd,
    output pal_pkg::t_dp_stat o_stat,
    output logic              o_done,
    output pal_pkg::t_result  o_result
);
    import pal_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > POS_W) ? CW : POS_W;

    logic [ITEM_WIDTH-1:0] r_mem [DEPTH];

    t_op                   r_op;
    logic [POS_W-1:0]      r_pos;
    logic [ITEM_WIDTH-1:0] r_val;
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         n_count;
    logic [CW-1:0]         r_cur;
    logic [CW-1:0]         n_cur;
    logic [ITEM_WIDTH-1:0] r_taken;
    logic [ITEM_WIDTH-1:0] r_rd_data;
    logic                  r_wp_valid;
    logic [AW-1:0]         r_wp_addr;
    logic                  r_done;
    t_result               r_result;
    t_result               n_result;

    logic [XW-1:0]         pos_x;
    logic [XW-1:0]         cnt_x;
    logic [XW-1:0]         cur_x;
    logic [XW-1:0]         pos_inc;
    logic [CW-1:0]         cur_dec;
    logic                  is_rem;
    logic                  ok;
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [ITEM_WIDTH-1:0] wr_data;

    always_comb begin
        pos_x   = XW'(r_pos);
        cnt_x   = XW'(r_count);
        cur_x   = XW'(r_cur);
        pos_inc = pos_x + XW'(1);
        cur_dec = r_cur - CW'(1);
        is_rem  = (r_op == OP_REMOVE);
        if (is_rem) begin
            ok = (r_count != '0) && (pos_x < cnt_x);
        end else begin
            ok = (r_count != CW'(DEPTH)) && (pos_x <= cnt_x);
        end

        o_stat.ok        = ok;
        o_stat.is_remove = is_rem;
        // insert walks down to the position, remove walks up to the count
        o_stat.cur_end   = is_rem ? (r_cur == r_count) : (cur_x == pos_x);

        rd_en = i_cmd.rd_take | i_cmd.shift;
        if (i_cmd.rd_take) begin
            rd_addr = pos_x[AW-1:0];
        end else if (is_rem) begin
            rd_addr = r_cur[AW-1:0];
        end else begin
            rd_addr = cur_dec[AW-1:0];
        end

        // pending shift write has priority; put only follows a drain
        wr_en   = r_wp_valid | i_cmd.put;
        wr_addr = r_wp_valid ? r_wp_addr : pos_x[AW-1:0];
        wr_data = r_wp_valid ? r_rd_data : r_val;

        n_cur = r_cur;
        if (i_cmd.init_cur) begin
            n_cur = is_rem ? CW'(pos_inc) : r_count;
        end else if (i_cmd.shift) begin
            n_cur = is_rem ? r_cur + CW'(1) : cur_dec;
        end

        n_count = r_count;
        if (i_cmd.finish && ok) begin
            n_count = is_rem ? r_count - CW'(1) : r_count + CW'(1);
        end

        n_result.accepted      = ok;
        n_result.removed_value = (ok && is_rem) ? VAL_W'(r_taken) : '0;
        n_result.entry_count   = CNT_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_wp_valid <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_count    <= n_count;
            r_wp_valid <= i_cmd.shift;
            r_done     <= i_cmd.finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_item.op;
            r_pos <= i_item.position;
            r_val <= i_item.item_value[ITEM_WIDTH-1:0];
        end
        if (i_cmd.grab) begin
            r_taken <= r_rd_data;
        end
        if (i_cmd.shift) begin
            r_wp_addr <= is_rem ? cur_dec[AW-1:0] : r_cur[AW-1:0];
        end
        if (i_cmd.finish) begin
            r_result <= n_result;
        end
        r_cur <= n_cur;
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

// File: sv/positional_array_list.sv
// positional_array_list: top level, ordered list with insert/remove at a position.
// Instantiates pal_ctrl and pal_dp; uses pal_pkg.
//
//   channel   ports                      transfer when
//   request   start, busy, i_item        start && !busy at a rising edge
//   result    o_done, o_result           o_done high (one cycle, no stall)
//
// An accepted request holds busy while it is carried out and also when it is
// refused. The shift moves one entry per cycle through the single write port
// of the entry memory.
// o_done pulses in the cycle busy drops; the next request may enter then.
// Reset clears the count and the controller; entry storage is not cleared.
module positional_array_list #(
    parameter int DEPTH      = pal_pkg::P_DEPTH,
    parameter int ITEM_WIDTH = pal_pkg::P_ITEM_WIDTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  pal_pkg::t_item   i_item,
    output logic             o_done,
    output pal_pkg::t_result o_result
);
    import pal_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    pal_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    pal_dp #(
        .DEPTH      (DEPTH),
        .ITEM_WIDTH (ITEM_WIDTH)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (cmd),
        .o_stat   (stat),
        .o_done   (o_done),
        .o_result (o_result)
    );

`ifndef SYNTH
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result strobe without a request in work");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    a_put_no_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.put |-> !$past(cmd.shift))
        else $error("new entry written while a shift write is pending");
`endif

endmodule
